### src/ffba_pkg.sv
// Package for the first-fit block allocator: sizes, operation and status codes,
// the table entry layout and the channel item types.
// No dependencies.
package ffba_pkg;

  localparam int MAX_BLOCKS   = 64;
  localparam int HEADER_BYTES = 24;
  localparam int ADDR_W       = 24;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
  localparam int NEED_W       = ADDR_W + 2;

  localparam logic [ADDR_W-1:0] HEAP_LIMIT_RST = 24'd65536;

  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_FREE    = 2'd1;
  localparam logic [1:0] KIND_REALLOC = 2'd2;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ZERO    = 2'd1,
    ST_NOSPACE = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] request_size;
    logic [ADDR_W-1:0] block_address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_address;
    logic [1:0]        status;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] start;
    logic [ADDR_W-1:0] size;
    logic              free;
  } entry_t;

endpackage

### src/first_fit_block_allocator.sv
// First-fit block allocator: block table in one synchronous memory, scanned by
// a sequencer through a registered read port. Depends on ffba_pkg.
//
// Usage: an item on in_* (valid/ready) carries kind, request_size and
// block_address; each item yields exactly one item on out_* (valid/ready)
// with result_address and status. cfg_* writes heap_limit (24 bits) and is
// always ready; write it only while no item is in flight.
// One item at a time: in_ready is high only in idle, which is entered as each result loads.
// Steps per item kind; the table holds at most 64 entries in use:
//   free of null, unknown kind: straight to the result; allocate of zero bytes: size check
//   allocate: scan one entry per cycle for a free fit, else append
//   free: address scan, then release
//   reallocate: address scan, then allocate and release if the block is too small
// The per-entry scan runs through the table memory read port.
// A finished result waits in the output register; while out_ready is low the
// sequencer may accept and finish the next item, then holds it until the
// output register frees up.
// Reset (rst_n low at a clock edge) empties the table, sets heap_top to 0 and
// heap_limit to 65536; the table memory itself is not cleared.
module first_fit_block_allocator (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  ffba_pkg::in_item_t            in_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output ffba_pkg::out_item_t           out_item,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ffba_pkg::ADDR_W-1:0]   cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_SCAN,
    S_APPEND,
    S_REL,
    S_OUT
  } state_t;

  localparam logic [ffba_pkg::ADDR_W-1:0] HDR_A =
    ffba_pkg::ADDR_W'(ffba_pkg::HEADER_BYTES);
  localparam logic [ffba_pkg::NEED_W-1:0] HDR_N =
    ffba_pkg::NEED_W'(ffba_pkg::HEADER_BYTES);
  localparam logic [ffba_pkg::CNT_W-1:0] CNT_MAX =
    ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS);
  localparam logic [ffba_pkg::CNT_W-1:0] CNT_ONE = ffba_pkg::CNT_W'(1);

  ffba_pkg::entry_t mem [ffba_pkg::MAX_BLOCKS];
  ffba_pkg::entry_t rd_data_r;

  state_t                         state_r;
  logic [ffba_pkg::ADDR_W-1:0]    heap_limit_r;
  logic [ffba_pkg::ADDR_W-1:0]    heap_top_r;
  logic [ffba_pkg::CNT_W-1:0]     count_r;
  logic [1:0]                     op_kind_r;
  logic [ffba_pkg::ADDR_W-1:0]    op_size_r;
  logic [ffba_pkg::ADDR_W-1:0]    op_addr_r;
  logic                           mode_find_r;
  logic [ffba_pkg::CNT_W-1:0]     rd_idx_r;
  logic                           pend_r;
  logic [ffba_pkg::IDX_W-1:0]     pend_idx_r;
  logic [ffba_pkg::IDX_W-1:0]     f_idx_r;
  logic [ffba_pkg::ADDR_W-1:0]    f_start_r;
  logic [ffba_pkg::ADDR_W-1:0]    f_size_r;
  logic [ffba_pkg::ADDR_W-1:0]    res_r;
  ffba_pkg::status_t              st_r;
  logic                           out_valid_r;
  ffba_pkg::out_item_t            out_item_r;

  logic [ffba_pkg::ADDR_W-1:0]    cur_payload;
  logic                           scan_hit;
  logic                           scan_more;
  logic [ffba_pkg::NEED_W-1:0]    need;
  logic                           app_ok;
  logic                           is_top;
  logic                           re_release;
  logic                           mem_we;
  logic [ffba_pkg::IDX_W-1:0]     mem_wa;
  ffba_pkg::entry_t               mem_wd;
  logic [ffba_pkg::IDX_W-1:0]     mem_ra;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    cur_payload = rd_data_r.start + HDR_A;
    if (mode_find_r) begin
      scan_hit = pend_r && (cur_payload == op_addr_r);
    end else begin
      scan_hit = pend_r && rd_data_r.free && (rd_data_r.size >= op_size_r);
    end
    scan_more  = (rd_idx_r < count_r);
    need       = {2'b00, heap_top_r} + HDR_N + {2'b00, op_size_r};
    app_ok     = (need <= {2'b00, heap_limit_r}) && (count_r != CNT_MAX);
    is_top     = ({1'b0, f_idx_r} + CNT_ONE) == count_r;
    re_release = (op_kind_r == ffba_pkg::KIND_REALLOC) &&
                 (op_addr_r != '0);
    mem_ra     = rd_idx_r[ffba_pkg::IDX_W-1:0];
    mem_we     = 1'b0;
    mem_wa     = pend_idx_r;
    mem_wd     = '{start: rd_data_r.start, size: rd_data_r.size, free: 1'b0};
    case (state_r)
      S_SCAN: begin
        mem_we = scan_hit && !mode_find_r;
      end
      S_APPEND: begin
        mem_we = app_ok;
        mem_wa = count_r[ffba_pkg::IDX_W-1:0];
        mem_wd = '{start: heap_top_r, size: op_size_r, free: 1'b0};
      end
      S_REL: begin
        mem_we = !is_top;
        mem_wa = f_idx_r;
        mem_wd = '{start: f_start_r, size: f_size_r, free: 1'b1};
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      heap_limit_r <= ffba_pkg::HEAP_LIMIT_RST;
      heap_top_r   <= '0;
      count_r      <= '0;
      pend_r       <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_valid) begin
        heap_limit_r <= cfg_data;
      end
      if (out_valid_r && out_ready && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_kind_r   <= in_item.kind;
            op_size_r   <= in_item.request_size;
            op_addr_r   <= in_item.block_address;
            res_r       <= '0;
            st_r        <= ffba_pkg::ST_OK;
            mode_find_r <= 1'b1;
            rd_idx_r    <= '0;
            pend_r      <= 1'b0;
            case (in_item.kind)
              ffba_pkg::KIND_ALLOC: begin
                state_r <= S_ALLOC;
              end
              ffba_pkg::KIND_FREE: begin
                state_r <= (in_item.block_address == '0) ? S_OUT : S_SCAN;
              end
              ffba_pkg::KIND_REALLOC: begin
                state_r <= (in_item.block_address == '0) ? S_ALLOC : S_SCAN;
              end
              default: begin
                state_r <= S_OUT;
              end
            endcase
          end
        end
        S_ALLOC: begin
          if (op_size_r == '0) begin
            st_r    <= ffba_pkg::ST_ZERO;
            state_r <= S_OUT;
          end else begin
            mode_find_r <= 1'b0;
            rd_idx_r    <= '0;
            pend_r      <= 1'b0;
            state_r     <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_hit) begin
            pend_r <= 1'b0;
            if (mode_find_r) begin
              f_idx_r   <= pend_idx_r;
              f_start_r <= rd_data_r.start;
              f_size_r  <= rd_data_r.size;
              if (op_kind_r == ffba_pkg::KIND_FREE) begin
                state_r <= S_REL;
              end else if (rd_data_r.size >= op_size_r) begin
                res_r   <= op_addr_r;
                state_r <= S_OUT;
              end else begin
                state_r <= S_ALLOC;
              end
            end else begin
              res_r   <= cur_payload;
              state_r <= re_release ? S_REL : S_OUT;
            end
          end else if (scan_more) begin
            pend_r     <= 1'b1;
            pend_idx_r <= rd_idx_r[ffba_pkg::IDX_W-1:0];
            rd_idx_r   <= rd_idx_r + CNT_ONE;
          end else begin
            pend_r <= 1'b0;
            if (mode_find_r) begin
              st_r    <= ffba_pkg::ST_UNKNOWN;
              state_r <= S_OUT;
            end else begin
              state_r <= S_APPEND;
            end
          end
        end
        S_APPEND: begin
          if (app_ok) begin
            count_r    <= count_r + CNT_ONE;
            res_r      <= heap_top_r + HDR_A;
            heap_top_r <= need[ffba_pkg::ADDR_W-1:0];
            state_r    <= re_release ? S_REL : S_OUT;
          end else begin
            st_r    <= ffba_pkg::ST_NOSPACE;
            state_r <= S_OUT;
          end
        end
        S_REL: begin
          if (is_top) begin
            heap_top_r <= f_start_r;
            count_r    <= count_r - CNT_ONE;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_item_r  <= '{result_address: res_r, status: st_r};
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_MAX)
    else $error("block count exceeds table depth");

  a_table_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r != S_IDLE) && (state_r != S_OUT))
    else $error("table written outside an operation");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r > $past(count_r))) |-> (heap_top_r > $past(heap_top_r)))
    else $error("append did not raise heap top");

  a_pop_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (count_r < $past(count_r))) |-> (heap_top_r < $past(heap_top_r)))
    else $error("pop did not lower heap top");

endmodule

### dv/tb.sv
`timescale 1ns / 1ps
// Testbench for first_fit_block_allocator: drives allocate, free, reallocate and unknown-kind items
// through valid/ready, predicts every result with its own heap table model and checks
// each one in order. Depends on ffba_pkg and the allocator RTL.
module tb;

  typedef logic [ffba_pkg::ADDR_W-1:0] addr_t;

  localparam logic [1:0] KIND_UNUSED   = 2'd3;
  localparam int         SETTLE_CYCLES = 160;
  localparam int         HOLD_CYCLES   = 300;
  localparam addr_t      HDR_A         = addr_t'(ffba_pkg::HEADER_BYTES);

  class alloc_scoreboard;
    addr_t               blk_start [ffba_pkg::MAX_BLOCKS];
    addr_t               blk_size  [ffba_pkg::MAX_BLOCKS];
    bit                  blk_free  [ffba_pkg::MAX_BLOCKS];
    int unsigned         blk_count;
    addr_t               top;
    addr_t               limit;
    addr_t               last_address;
    ffba_pkg::out_item_t pending_replies[$];
    int                  mismatches;

    function new();
      blk_count    = 0;
      top          = '0;
      limit        = ffba_pkg::HEAP_LIMIT_RST;
      last_address = '0;
      mismatches   = 0;
    endfunction

    function int locate(addr_t addr);
      addr_t payload;
      for (int i = 0; i < blk_count; i++) begin
        payload = blk_start[i] + HDR_A;
        if (payload == addr) return i;
      end
      return ffba_pkg::MAX_BLOCKS;
    endfunction

    function ffba_pkg::status_t claim(addr_t size, output addr_t addr);
      int unsigned need;
      addr = '0;
      if (size == 0) return ffba_pkg::ST_ZERO;
      for (int i = 0; i < blk_count; i++) begin
        if (blk_free[i] && blk_size[i] >= size) begin
          blk_free[i] = 1'b0;
          addr = blk_start[i] + HDR_A;
          return ffba_pkg::ST_OK;
        end
      end
      need = {8'd0, top} + {8'd0, HDR_A} + {8'd0, size};
      if (need > {8'd0, limit} || blk_count >= ffba_pkg::MAX_BLOCKS)
        return ffba_pkg::ST_NOSPACE;
      blk_start[blk_count] = top;
      blk_size[blk_count]  = size;
      blk_free[blk_count]  = 1'b0;
      blk_count++;
      addr = top + HDR_A;
      top  = addr_t'(need);
      return ffba_pkg::ST_OK;
    endfunction

    function void drop_block(int idx);
      if (idx + 1 == blk_count) begin
        top = blk_start[idx];
        blk_count--;
      end else begin
        blk_free[idx] = 1'b1;
      end
    endfunction

    function void note_request(ffba_pkg::in_item_t it);
      ffba_pkg::out_item_t want;
      addr_t               addr;
      ffba_pkg::status_t   st;
      int                  idx;
      addr = '0;
      st   = ffba_pkg::ST_OK;
      case (it.kind)
        ffba_pkg::KIND_ALLOC: begin
          st = claim(it.request_size, addr);
        end
        ffba_pkg::KIND_FREE: begin
          if (it.block_address != 0) begin
            idx = locate(it.block_address);
            if (idx >= ffba_pkg::MAX_BLOCKS) st = ffba_pkg::ST_UNKNOWN;
            else drop_block(idx);
          end
        end
        ffba_pkg::KIND_REALLOC: begin
          if (it.block_address == 0) begin
            st = claim(it.request_size, addr);
          end else begin
            idx = locate(it.block_address);
            if (idx >= ffba_pkg::MAX_BLOCKS) begin
              st = ffba_pkg::ST_UNKNOWN;
            end else if (blk_size[idx] >= it.request_size) begin
              addr = it.block_address;
            end else begin
              st = claim(it.request_size, addr);
              if (st == ffba_pkg::ST_OK) drop_block(idx);
            end
          end
        end
        default: begin
        end
      endcase
      want.result_address = addr;
      want.status         = st;
      pending_replies.push_back(want);
      last_address = addr;
    endfunction

    function void check_result(ffba_pkg::out_item_t got);
      ffba_pkg::out_item_t want;
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: addr %h status %0d", got.result_address, got.status);
        return;
      end
      want = pending_replies.pop_front();
      if (got.result_address !== want.result_address || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected addr %h status %0d, got addr %h status %0d",
                   want.result_address, want.status, got.result_address, got.status);
      end
    endfunction
  endclass

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  ffba_pkg::in_item_t  in_item   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  ffba_pkg::out_item_t out_item;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  addr_t               cfg_data  = '0;

  alloc_scoreboard sb = new();

  int idle_pct    = 0;
  int stall_pct   = 0;
  bit pressure_on = 1'b0;
  bit held_once   = 1'b0;
  int hold_left   = 0;

  first_fit_block_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left--;
    end else if (pressure_on && (!held_once || $urandom_range(199) == 0)) begin
      held_once = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_item);
  end

  function automatic addr_t pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 65) return addr_t'($urandom_range(64, 1));
    if (r < 90) return addr_t'($urandom_range(1024, 65));
    if (r < 97) return addr_t'($urandom_range(65536, 1025));
    return addr_t'($urandom);
  endfunction

  function automatic addr_t live_address();
    int idx;
    if (sb.blk_count == 0) return addr_t'($urandom);
    idx = $urandom_range(sb.blk_count - 1);
    return sb.blk_start[idx] + HDR_A;
  endfunction

  function automatic ffba_pkg::in_item_t make_item();
    ffba_pkg::in_item_t it;
    int                 r;
    it.kind          = ffba_pkg::KIND_ALLOC;
    it.request_size  = pick_size();
    it.block_address = '0;
    r = $urandom_range(99);
    if (r < 40) begin
    end else if (r < 65) begin
      it.kind          = ffba_pkg::KIND_FREE;
      it.block_address = live_address();
    end else if (r < 80) begin
      it.kind          = ffba_pkg::KIND_REALLOC;
      it.block_address = live_address();
    end else if (r < 85) begin
      it.kind = ffba_pkg::KIND_REALLOC;
    end else if (r < 89) begin
      it.kind = ffba_pkg::KIND_FREE;
    end else if (r < 96) begin
      it.kind          = r[0] ? ffba_pkg::KIND_FREE : ffba_pkg::KIND_REALLOC;
      it.block_address = addr_t'($urandom);
    end else begin
      it.kind          = KIND_UNUSED;
      it.request_size  = addr_t'($urandom);
      it.block_address = addr_t'($urandom);
    end
    return it;
  endfunction

  task automatic send_item(ffba_pkg::in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    sb.note_request(it);
  endtask

  task automatic send_op(logic [1:0] kind, addr_t size, addr_t addr);
    ffba_pkg::in_item_t it;
    it.kind          = kind;
    it.request_size  = size;
    it.block_address = addr;
    send_item(it);
  endtask

  task automatic run_random(int n);
    repeat (n) send_item(make_item());
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(addr_t value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.limit = value;
    cfg_valid <= 1'b0;
  endtask

  task automatic fill_table();
    addr_t widest;
    for (int n = 0; n < 200 && sb.blk_count < ffba_pkg::MAX_BLOCKS; n++)
      send_op(ffba_pkg::KIND_ALLOC, addr_t'($urandom_range(4096, 1)), '0);
    widest = '0;
    for (int i = 0; i < sb.blk_count; i++)
      if (sb.blk_size[i] > widest) widest = sb.blk_size[i];
    repeat (3) send_op(ffba_pkg::KIND_ALLOC, widest + 24'd1, '0);
  endtask

  initial begin
    addr_t a_blk, b_blk, c_blk, d_blk;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_op(ffba_pkg::KIND_ALLOC, '0, '0);
    send_op(ffba_pkg::KIND_FREE, 24'hFFFFFF, '0);
    send_op(KIND_UNUSED, 24'hFFFFFF, 24'hFFFFFF);
    send_op(ffba_pkg::KIND_FREE, '0, 24'hFFFFFF);
    send_op(ffba_pkg::KIND_REALLOC, 24'd16, HDR_A);
    send_op(ffba_pkg::KIND_ALLOC, 24'hFFFFFF, '0);
    send_op(ffba_pkg::KIND_ALLOC, 24'd100, '0);
    a_blk = sb.last_address;
    send_op(ffba_pkg::KIND_ALLOC, 24'd200, '0);
    b_blk = sb.last_address;
    send_op(ffba_pkg::KIND_ALLOC, 24'd50, '0);
    c_blk = sb.last_address;
    send_op(ffba_pkg::KIND_FREE, '0, a_blk);
    send_op(ffba_pkg::KIND_FREE, '0, a_blk);
    send_op(ffba_pkg::KIND_ALLOC, 24'd80, '0);
    send_op(ffba_pkg::KIND_REALLOC, 24'd100, a_blk);
    send_op(ffba_pkg::KIND_REALLOC, '0, a_blk);
    send_op(ffba_pkg::KIND_REALLOC, 24'd500, a_blk);
    d_blk = sb.last_address;
    send_op(ffba_pkg::KIND_FREE, '0, d_blk);
    send_op(ffba_pkg::KIND_REALLOC, 24'd30, '0);
    send_op(ffba_pkg::KIND_REALLOC, '0, '0);
    send_op(ffba_pkg::KIND_ALLOC, sb.limit - sb.top - HDR_A, '0);
    send_op(ffba_pkg::KIND_ALLOC, 24'd1000, '0);
    send_op(ffba_pkg::KIND_REALLOC, 24'd300, b_blk);
    send_op(ffba_pkg::KIND_FREE, '0, c_blk + 24'd1);
    settle();

    write_limit(24'hFFFFFF);
    fill_table();
    run_random(330);
    settle();

    write_limit('0);
    idle_pct = 81;
    run_random(150);
    settle();

    write_limit(24'd3000);
    idle_pct  = 0;
    stall_pct = 81;
    run_random(400);
    settle();

    write_limit(ffba_pkg::HEAP_LIMIT_RST);
    idle_pct  = 29;
    stall_pct = 29;
    run_random(400);
    settle();

    write_limit(addr_t'($urandom_range(200000, 2000)));
    idle_pct    = 0;
    stall_pct   = 0;
    pressure_on = 1'b1;
    run_random(480);
    settle();

    if (sb.mismatches == 0 && sb.pending_replies.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### filelist.f
src/ffba_pkg.sv
src/first_fit_block_allocator.sv
dv/tb.sv
